// ===== hdl/uartbf_pkg.sv =====
// shared types, codes and defaults of the serial-port buffer block
// no dependencies; used by every other file of the block except uartbf_ram
`default_nettype none

package uartbf_pkg;

	// default buffer size of each ring buffer
	localparam int BUFFER_DEPTH = 64;

	// command codes of an input word
	localparam logic [2:0] CMD_RX_CHAR    = 3'd0;
	localparam logic [2:0] CMD_TX_READY   = 3'd1;
	localparam logic [2:0] CMD_HOST_WRITE = 3'd2;
	localparam logic [2:0] CMD_HOST_READ  = 3'd3;
	localparam logic [2:0] CMD_FLUSH_RX   = 3'd4;
	localparam logic [2:0] CMD_FLUSH_TX   = 3'd5;

	// result codes
	localparam logic [2:0] RES_OK        = 3'd0;
	localparam logic [2:0] RES_OVERFLOW  = 3'd1;
	localparam logic [2:0] RES_NOT_READY = 3'd2;
	localparam logic [2:0] RES_TX_DONE   = 3'd3;
	localparam logic [2:0] RES_HW_ERROR  = 3'd4;

	// error kinds
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_FRAMING  = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;
	localparam logic [1:0] ERR_PARITY   = 2'd3;

	typedef logic [6:0]  level_t;
	typedef logic [15:0] count_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic       framing_flag;
		logic       overrun_flag;
		logic       parity_flag;
	} item_t;

	typedef struct packed {
		logic [2:0] result_code;
		logic [7:0] out_byte;
		logic [1:0] error_kind;
		logic [1:0] latest_error;
		level_t     rx_level;
		level_t     tx_level;
		logic       tx_irq_enabled;
		count_t     error_total;
		count_t     overflow_total;
		count_t     framing_total;
		count_t     parity_total;
		count_t     sent_total;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_valid;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/uartbf_stream_if.sv =====
// valid/ready channels for input words and result words
// depends on uartbf_pkg
`default_nettype none

interface uartbf_item_if;
	logic               valid;
	logic               ready;
	uartbf_pkg::item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface uartbf_result_if;
	logic                 valid;
	logic                 ready;
	uartbf_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/uartbf_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module uartbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/uartbf_ctrl.sv =====
// controller: takes one word, runs it once the result register is free
// depends on uartbf_pkg
`default_nettype none

module uartbf_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output      logic                   item_ready,
	input  wire logic                   result_ready,
	input  wire uartbf_pkg::dp_status_t status,
	output      uartbf_pkg::ctrl_cmd_t  cmd
);

	uartbf_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uartbf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			uartbf_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = uartbf_pkg::ST_EXEC;
				end
			end
			uartbf_pkg::ST_EXEC: begin
				// result register free or being emptied this cycle
				if (!status.out_valid || result_ready) begin
					cmd.exec = 1'b1;
					state_d  = uartbf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = uartbf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/uartbf_datapath.sv =====
// datapath: ring buffers, pointers, counters and the result register
// depends on uartbf_pkg and uartbf_ram
`default_nettype none

module uartbf_datapath #(
	parameter int BUFFER_DEPTH = uartbf_pkg::BUFFER_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire uartbf_pkg::ctrl_cmd_t  cmd,
	input  wire uartbf_pkg::item_t      item,
	input  wire logic                   result_ready,
	output      uartbf_pkg::result_t    result,
	output      logic                   result_valid,
	output      uartbf_pkg::dp_status_t status
);

	localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int FW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(BUFFER_DEPTH - 1);
	localparam logic [FW-1:0] FULL     = FW'(BUFFER_DEPTH);

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction

	uartbf_pkg::item_t item_q;

	logic [PW-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [FW-1:0] rx_fill_q, tx_fill_q;
	logic          tx_en_q;
	logic [1:0]    last_err_q;
	uartbf_pkg::count_t err_q, ovf_q, frame_q, par_q, sent_q;

	logic [PW-1:0] rx_head_d, rx_tail_d, tx_head_d, tx_tail_d;
	logic [FW-1:0] rx_fill_d, tx_fill_d;
	logic          tx_en_d;
	logic [1:0]    last_err_d;
	uartbf_pkg::count_t err_d, ovf_d, frame_d, par_d, sent_d;

	logic [2:0] code;
	logic [1:0] kind;
	logic [7:0] ob;
	logic       rx_we, tx_we;
	logic [7:0] rx_rdata, tx_rdata;

	uartbf_pkg::result_t out_q;
	logic                out_valid_q;

	// reads are launched as the word is taken, data is ready for the execute cycle
	uartbf_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_tail_q),
		.wdata (item_q.data_byte),
		.re    (cmd.accept),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	uartbf_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_tail_q),
		.wdata (item_q.data_byte),
		.re    (cmd.accept),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			out_q.result_code    <= code;
			out_q.out_byte       <= ob;
			out_q.error_kind     <= kind;
			out_q.latest_error   <= last_err_d;
			out_q.rx_level       <= uartbf_pkg::level_t'(rx_fill_d);
			out_q.tx_level       <= uartbf_pkg::level_t'(tx_fill_d);
			out_q.tx_irq_enabled <= tx_en_d;
			out_q.error_total    <= err_d;
			out_q.overflow_total <= ovf_d;
			out_q.framing_total  <= frame_d;
			out_q.parity_total   <= par_d;
			out_q.sent_total     <= sent_d;
		end
	end

	always_comb begin
		rx_head_d  = rx_head_q;
		rx_tail_d  = rx_tail_q;
		rx_fill_d  = rx_fill_q;
		tx_head_d  = tx_head_q;
		tx_tail_d  = tx_tail_q;
		tx_fill_d  = tx_fill_q;
		tx_en_d    = tx_en_q;
		last_err_d = last_err_q;
		err_d      = err_q;
		ovf_d      = ovf_q;
		frame_d    = frame_q;
		par_d      = par_q;
		sent_d     = sent_q;
		code       = uartbf_pkg::RES_OK;
		kind       = uartbf_pkg::ERR_NONE;
		ob         = '0;
		rx_we      = 1'b0;
		tx_we      = 1'b0;
		unique case (item_q.command)
			uartbf_pkg::CMD_RX_CHAR: begin
				if (item_q.framing_flag || item_q.overrun_flag || item_q.parity_flag) begin
					err_d = err_q + 1'b1;
					if (item_q.framing_flag) begin
						frame_d = frame_q + 1'b1;
					end
					if (item_q.overrun_flag) begin
						ovf_d = ovf_q + 1'b1;
					end
					if (item_q.parity_flag) begin
						par_d = par_q + 1'b1;
					end
					// parity over overrun over framing
					if (item_q.parity_flag) begin
						kind = uartbf_pkg::ERR_PARITY;
					end else if (item_q.overrun_flag) begin
						kind = uartbf_pkg::ERR_OVERFLOW;
					end else begin
						kind = uartbf_pkg::ERR_FRAMING;
					end
					last_err_d = kind;
					code       = uartbf_pkg::RES_HW_ERROR;
				end else if (rx_fill_q == FULL) begin
					ovf_d      = ovf_q + 1'b1;
					kind       = uartbf_pkg::ERR_OVERFLOW;
					last_err_d = uartbf_pkg::ERR_OVERFLOW;
					code       = uartbf_pkg::RES_OVERFLOW;
				end else begin
					rx_we     = cmd.exec;
					rx_tail_d = advance(rx_tail_q);
					rx_fill_d = rx_fill_q + 1'b1;
				end
			end
			uartbf_pkg::CMD_TX_READY: begin
				if (tx_fill_q != '0) begin
					ob        = tx_rdata;
					tx_head_d = advance(tx_head_q);
					tx_fill_d = tx_fill_q - 1'b1;
					sent_d    = sent_q + 1'b1;
				end else begin
					tx_en_d = 1'b0;
					code    = uartbf_pkg::RES_TX_DONE;
				end
			end
			uartbf_pkg::CMD_HOST_WRITE: begin
				if (tx_fill_q != FULL) begin
					tx_we     = cmd.exec;
					tx_tail_d = advance(tx_tail_q);
					tx_fill_d = tx_fill_q + 1'b1;
					tx_en_d   = 1'b1;
				end else begin
					code = uartbf_pkg::RES_OVERFLOW;
				end
			end
			uartbf_pkg::CMD_HOST_READ: begin
				if (rx_fill_q != '0) begin
					ob        = rx_rdata;
					rx_head_d = advance(rx_head_q);
					rx_fill_d = rx_fill_q - 1'b1;
				end else begin
					code = uartbf_pkg::RES_NOT_READY;
				end
			end
			uartbf_pkg::CMD_FLUSH_RX: begin
				rx_head_d = '0;
				rx_tail_d = '0;
				rx_fill_d = '0;
			end
			uartbf_pkg::CMD_FLUSH_TX: begin
				tx_head_d = '0;
				tx_tail_d = '0;
				tx_fill_d = '0;
				tx_en_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			rx_fill_q   <= '0;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			tx_fill_q   <= '0;
			tx_en_q     <= 1'b0;
			last_err_q  <= uartbf_pkg::ERR_NONE;
			err_q       <= '0;
			ovf_q       <= '0;
			frame_q     <= '0;
			par_q       <= '0;
			sent_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				rx_head_q  <= rx_head_d;
				rx_tail_q  <= rx_tail_d;
				rx_fill_q  <= rx_fill_d;
				tx_head_q  <= tx_head_d;
				tx_tail_q  <= tx_tail_d;
				tx_fill_q  <= tx_fill_d;
				tx_en_q    <= tx_en_d;
				last_err_q <= last_err_d;
				err_q      <= err_d;
				ovf_q      <= ovf_d;
				frame_q    <= frame_d;
				par_q      <= par_d;
				sent_q     <= sent_d;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result           = out_q;
	assign result_valid     = out_valid_q;
	assign status.out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/uart_buffered_fifo_with_error_stats_core.sv =====
// top level: serial-port receive/transmit ring buffers with error counters
// depends on uartbf_pkg, uartbf_stream_if, uartbf_ctrl, uartbf_datapath
// a taken word is held through the exec state, and its result word is registered as exec runs
//   (exec waits while the previous result still waits for the receiver)
// no new word is taken until the last one has run, as the buffer ram read is registered
//   (read launched as the word is taken, the word is executed in the exec state)
// a finished result waits in its own register while the next word is taken
// reset (arst_n low, asynchronous): pointers, levels, counters and last error go to 0,
//   buffer ram contents are not cleared and no clearing pass runs
`default_nettype none

module uart_buffered_fifo_with_error_stats_core #(
	parameter int BUFFER_DEPTH = uartbf_pkg::BUFFER_DEPTH
) (
	input wire logic        clk,
	input wire logic        arst_n,
	uartbf_item_if.sink     item,
	uartbf_result_if.source result
);

	uartbf_pkg::ctrl_cmd_t  ctrl_cmd;
	uartbf_pkg::dp_status_t dp_status;

	// state machine: idle takes a word, exec runs it when the result register is free
	uartbf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_ready (result.ready),
		.status       (dp_status),
		.cmd          (ctrl_cmd)
	);

	// buffers, pointers, counters and the result register
	uartbf_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctrl_cmd),
		.item         (item.data),
		.result_ready (result.ready),
		.result       (result.data),
		.result_valid (result.valid),
		.status       (dp_status)
	);

	// a word is never taken in the cycle it runs
	a_accept_not_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_cmd.accept && ctrl_cmd.exec))
		else $error("accept and exec in the same cycle");

	// one word at a time: after a word is taken the input stalls for its execute cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("input taken while a word is in flight");

	// execution never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.exec |-> (!result.valid || result.ready))
		else $error("result register overwritten");

	// every executed word shows up as a result in the next cycle
	a_exec_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.exec |=> result.valid)
		else $error("executed word gave no result");

endmodule

`default_nettype wire
